FILE: rtl/dmsp_pkg.sv
// shared constants, state encoding and control word types for the shortest path engine
`default_nettype none

package dmsp_pkg;

	// default sizing
	localparam int MAX_VERTICES = 32;
	localparam int WEIGHT_BITS  = 8;

	// fixed field widths
	localparam int VERTEX_BITS = 5;
	localparam int DIST_BITS   = 20;
	localparam int VCOUNT_BITS = 6;

	// distance shown for an unreachable vertex
	localparam logic [DIST_BITS-1:0] DIST_INF = DIST_BITS'(999999);

	// configuration register
	localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = VCOUNT_BITS'(32);
	localparam logic [2:0] REG_VERTEX_COUNT_ADDR = 3'd0;

	// operation codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// controller states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_SEL,
		ST_MARK,
		ST_REL,
		ST_NEXT,
		ST_DST,
		ST_DSTW,
		ST_WALK,
		ST_WALKW,
		ST_EMIT,
		ST_FAIL
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic clear_step;
		logic load;
		logic query_start;
		logic sel_run;
		logic mark;
		logic rel_run;
		logic next_round;
		logic dst_read;
		logic dst_latch;
		logic walk_step;
		logic walk_follow;
		logic emit_step;
		logic fail;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic clear_done;
		logic bad_query;
		logic single;
		logic scan_done;
		logic last_round;
		logic unreach;
		logic walk_stop;
		logic emit_end;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/dmsp_ctrl.sv
// controller state machine sequencing clear, load, scan rounds, path walk and emit
`default_nettype none

module dmsp_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               op,
	input  dmsp_pkg::dp_stat_t      stat,
	output logic                    busy,
	output dmsp_pkg::dp_cmd_t       cmd
);
	import dmsp_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					if (op == OP_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.query_start = 1'b1;
						state_d         = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (stat.bad_query) state_d = ST_FAIL;
				else if (stat.single) state_d = ST_DST;
				else state_d = ST_SEL;
			end
			ST_SEL: begin
				cmd.sel_run = 1'b1;
				if (stat.scan_done) state_d = ST_MARK;
			end
			ST_MARK: begin
				cmd.mark = 1'b1;
				state_d  = ST_REL;
			end
			ST_REL: begin
				cmd.rel_run = 1'b1;
				if (stat.scan_done) state_d = ST_NEXT;
			end
			ST_NEXT: begin
				cmd.next_round = 1'b1;
				if (stat.last_round) state_d = ST_DST;
				else state_d = ST_SEL;
			end
			ST_DST: begin
				cmd.dst_read = 1'b1;
				state_d      = ST_DSTW;
			end
			ST_DSTW: begin
				cmd.dst_latch = 1'b1;
				if (stat.unreach) state_d = ST_FAIL;
				else state_d = ST_WALK;
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (stat.walk_stop) state_d = ST_EMIT;
				else state_d = ST_WALKW;
			end
			ST_WALKW: begin
				cmd.walk_follow = 1'b1;
				state_d         = ST_WALK;
			end
			ST_EMIT: begin
				cmd.emit_step = 1'b1;
				if (stat.emit_end) state_d = ST_IDLE;
			end
			ST_FAIL: begin
				cmd.fail = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/dmsp_datapath.sv
// datapath: weight, distance, predecessor and path memories with scan pipeline
`default_nettype none

module dmsp_datapath #(
	parameter int MAX_VERTICES = dmsp_pkg::MAX_VERTICES,
	parameter int WEIGHT_BITS  = dmsp_pkg::WEIGHT_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  dmsp_pkg::dp_cmd_t                        cmd,
	output dmsp_pkg::dp_stat_t                       stat,
	input  wire logic [dmsp_pkg::VCOUNT_BITS-1:0]    vcount,
	input  wire logic [dmsp_pkg::VERTEX_BITS-1:0]    from_vertex,
	input  wire logic [dmsp_pkg::VERTEX_BITS-1:0]    to_vertex,
	input  wire logic [7:0]                          edge_weight,
	input  wire logic [dmsp_pkg::VERTEX_BITS-1:0]    source,
	input  wire logic [dmsp_pkg::VERTEX_BITS-1:0]    destination,
	output logic                                     done,
	output logic [dmsp_pkg::VERTEX_BITS-1:0]         path_vertex,
	output logic [dmsp_pkg::DIST_BITS-1:0]           total_distance,
	output logic                                     last
);
	import dmsp_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int AW = 2 * VW;
	localparam int WDEPTH = 1 << AW;
	localparam int CW = DIST_BITS + 1;

	// memories
	logic [WEIGHT_BITS-1:0] wmem [WDEPTH];
	logic [DIST_BITS-1:0]   dmem [MAX_VERTICES];
	logic [VW-1:0]          pmem [MAX_VERTICES];
	logic [VW-1:0]          bmem [MAX_VERTICES];

	logic [WEIGHT_BITS-1:0] w_rd;
	logic [DIST_BITS-1:0]   d_rd;
	logic [VW-1:0]          p_rd;
	logic [VW-1:0]          b_rd;

	// control state
	logic [AW-1:0]           clr_q;
	logic [NW-1:0]           n_q;
	logic [VW-1:0]           dst_q;
	logic [VERTEX_BITS-1:0]  dst_in_q;
	logic                    bad_q;
	logic [NW-1:0]           idx_q;
	logic                    v_s1;
	logic [VW-1:0]           idx_s1;
	logic [DIST_BITS-1:0]    least_q;
	logic [VW-1:0]           cur_q;
	logic [NW-1:0]           round_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [MAX_VERTICES-1:0] reached_q;
	logic [MAX_VERTICES-1:0] pvalid_q;
	logic [DIST_BITS-1:0]    dst_dist_q;
	logic [VW-1:0]           walk_v_q;
	logic [NW-1:0]           len_q;
	logic [VW-1:0]           eidx_q;
	logic                    e_s1;
	logic                    last_s1;
	logic                    fail_s1;

	// combinational helpers
	logic [NW-1:0]          nv;
	logic                   issue;
	logic [DIST_BITS-1:0]   d_eff;
	logic [CW-1:0]          cand;
	logic                   relax_en;
	logic                   sel_take;
	logic                   load_ok;
	logic [VW-1:0]          src_idx;
	logic [VW-1:0]          dist_raddr;

	// active vertex count clamped to the supported range
	always_comb begin
		if (vcount == '0) nv = NW'(1);
		else if (int'(vcount) > MAX_VERTICES) nv = NW'(MAX_VERTICES);
		else nv = NW'(vcount);
	end

	assign src_idx    = VW'(source);
	assign issue      = (cmd.sel_run | cmd.rel_run) && (idx_q < n_q);
	assign d_eff      = reached_q[idx_s1] ? d_rd : DIST_INF;
	assign cand       = {1'b0, least_q} + CW'(w_rd);
	assign relax_en   = cmd.rel_run && v_s1 && !visited_q[idx_s1] && (w_rd != '0)
		&& (cand < {1'b0, d_eff});
	assign sel_take   = cmd.sel_run && v_s1 && !visited_q[idx_s1] && (d_eff <= least_q);
	assign load_ok    = (32'(from_vertex) < MAX_VERTICES) && (32'(to_vertex) < MAX_VERTICES);
	assign dist_raddr = cmd.dst_read ? dst_q : idx_q[VW-1:0];

	// weight memory: clearing pass, loads and row reads
	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			wmem[clr_q] <= '0;
		end else if (cmd.load && load_ok) begin
			wmem[{VW'(from_vertex), VW'(to_vertex)}] <= WEIGHT_BITS'(edge_weight);
		end
		w_rd <= wmem[{cur_q, idx_q[VW-1:0]}];
	end

	// distance memory: source seed and relaxation writes
	always_ff @(posedge clk) begin
		if (cmd.query_start) begin
			dmem[src_idx] <= '0;
		end else if (relax_en) begin
			dmem[idx_s1] <= cand[DIST_BITS-1:0];
		end
		d_rd <= dmem[dist_raddr];
	end

	// predecessor memory
	always_ff @(posedge clk) begin
		if (relax_en) begin
			pmem[idx_s1] <= cur_q;
		end
		p_rd <= pmem[walk_v_q];
	end

	// path buffer, written destination first, read back in reverse
	always_ff @(posedge clk) begin
		if (cmd.walk_step) begin
			bmem[len_q[VW-1:0]] <= walk_v_q;
		end
		b_rd <= bmem[eidx_q];
	end

	// query payload registers
	always_ff @(posedge clk) begin
		if (cmd.query_start) begin
			n_q      <= nv;
			dst_q    <= VW'(destination);
			dst_in_q <= destination;
		end
		if (cmd.dst_latch) begin
			dst_dist_q <= d_rd;
		end
	end

	// scan, round and walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			bad_q     <= 1'b0;
			idx_q     <= '0;
			v_s1      <= 1'b0;
			idx_s1    <= '0;
			least_q   <= DIST_INF;
			cur_q     <= '0;
			round_q   <= '0;
			visited_q <= '0;
			reached_q <= '0;
			pvalid_q  <= '0;
			walk_v_q  <= '0;
			len_q     <= '0;
			eidx_q    <= '0;
			e_s1      <= 1'b0;
			last_s1   <= 1'b0;
			fail_s1   <= 1'b0;
		end else begin
			v_s1    <= issue;
			idx_s1  <= idx_q[VW-1:0];
			e_s1    <= cmd.emit_step;
			last_s1 <= cmd.emit_step && (eidx_q == '0);
			fail_s1 <= cmd.fail;

			if (cmd.clear_step) clr_q <= clr_q + AW'(1);
			if (issue) idx_q <= idx_q + NW'(1);

			// query setup, only the source counts as reached
			if (cmd.query_start) begin
				bad_q     <= (32'(source) >= 32'(nv)) || (32'(destination) >= 32'(nv));
				idx_q     <= '0;
				least_q   <= DIST_INF;
				round_q   <= '0;
				visited_q <= '0;
				reached_q <= MAX_VERTICES'(1) << src_idx;
				pvalid_q  <= '0;
			end

			// least distance selection
			if (sel_take) begin
				least_q <= d_eff;
				cur_q   <= idx_s1;
			end

			if (cmd.mark) begin
				visited_q[cur_q] <= 1'b1;
				idx_q            <= '0;
			end

			// relaxation of the selected row
			if (relax_en) begin
				reached_q[idx_s1] <= 1'b1;
				pvalid_q[idx_s1]  <= 1'b1;
			end

			if (cmd.next_round) begin
				round_q <= round_q + NW'(1);
				idx_q   <= '0;
				least_q <= DIST_INF;
			end

			// predecessor walk from destination
			if (cmd.dst_latch) begin
				walk_v_q <= dst_q;
				len_q    <= '0;
			end
			if (cmd.walk_step) begin
				len_q  <= len_q + NW'(1);
				eidx_q <= len_q[VW-1:0];
			end
			if (cmd.walk_follow) walk_v_q <= p_rd;
			if (cmd.emit_step) eidx_q <= eidx_q - VW'(1);
		end
	end

	// status
	assign stat.clear_done = (clr_q == '1);
	assign stat.bad_query  = bad_q;
	assign stat.single     = (n_q == NW'(1));
	assign stat.scan_done  = v_s1 && (NW'(idx_s1) == n_q - NW'(1));
	assign stat.last_round = (round_q == n_q - NW'(2));
	assign stat.unreach    = !reached_q[dst_q];
	assign stat.walk_stop  = !pvalid_q[walk_v_q] || ((len_q + NW'(1)) >= n_q);
	assign stat.emit_end   = (eidx_q == '0);

	// result word
	assign done           = e_s1 | fail_s1;
	assign path_vertex    = fail_s1 ? dst_in_q : VERTEX_BITS'(b_rd);
	assign total_distance = fail_s1 ? DIST_INF : dst_dist_q;
	assign last           = fail_s1 | last_s1;

endmodule

`default_nettype wire

FILE: rtl/dijkstra_matrix_shortest_path.sv
// top level: register port, controller and datapath of the shortest path engine
//
//  channel   signals                                            handshake
//  input     op from_vertex to_vertex edge_weight source dest.   start and not busy
//  result    path_vertex total_distance last                    done, one cycle
//  config    psel penable pwrite paddr pwdata prdata             apb, pready always high
//
// a load is taken without going busy; a query runs n-1 rounds for n vertices, each with
// two scans of the distance memory, then walks and emits a path of L vertices
// after reset a clearing pass over all 2^(2*clog2(MAX_VERTICES)) entries (1024 by default)
// zeroes the weight memory, with busy high
// results cannot be stalled; each path word is shown for one cycle on done
`default_nettype none

module dijkstra_matrix_shortest_path #(
	parameter int MAX_VERTICES = dmsp_pkg::MAX_VERTICES,
	parameter int WEIGHT_BITS  = dmsp_pkg::WEIGHT_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic                             op,
	input  wire logic [dmsp_pkg::VERTEX_BITS-1:0] from_vertex,
	input  wire logic [dmsp_pkg::VERTEX_BITS-1:0] to_vertex,
	input  wire logic [7:0]                       edge_weight,
	input  wire logic [dmsp_pkg::VERTEX_BITS-1:0] source,
	input  wire logic [dmsp_pkg::VERTEX_BITS-1:0] destination,
	output logic                                  done,
	output logic [dmsp_pkg::VERTEX_BITS-1:0]      path_vertex,
	output logic [dmsp_pkg::DIST_BITS-1:0]        total_distance,
	output logic                                  last,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [2:0]                       paddr,
	input  wire logic [31:0]                      pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);
	import dmsp_pkg::*;

	logic [VCOUNT_BITS-1:0] vcount_q;
	dp_cmd_t                cmd;
	dp_stat_t               stat;
	logic                   reg_hit;

	// register port
	assign pready  = 1'b1;
	assign reg_hit = (paddr == REG_VERTEX_COUNT_ADDR);
	assign prdata  = reg_hit ? 32'(vcount_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			vcount_q <= pwdata[VCOUNT_BITS-1:0];
		end
	end

	// controller
	dmsp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// datapath
	dmsp_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.vcount         (vcount_q),
		.from_vertex    (from_vertex),
		.to_vertex      (to_vertex),
		.edge_weight    (edge_weight),
		.source         (source),
		.destination    (destination),
		.done           (done),
		.path_vertex    (path_vertex),
		.total_distance (total_distance),
		.last           (last)
	);

endmodule

`default_nettype wire

FILE: rtl/dmsp_checker.sv
// port level checks of the shortest path engine and their binding
`default_nettype none

module dmsp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        op,
	input wire logic        done,
	input wire logic        last,
	input wire logic [19:0] total_distance
);
	import dmsp_pkg::*;

	// a result word only follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result word without a busy cycle before it");

	// the final word of a query is never followed at once by another word
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(done && last) |=> !done)
		else $error("result word right after the final word");

	// a load is taken without the block going busy
	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_LOAD) |=> !busy)
		else $error("load did not complete in one cycle");

	// an accepted query makes the block busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_QUERY) |=> busy)
		else $error("query accepted without going busy");

	// reported distance never exceeds the unreachable mark
	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (total_distance <= DIST_INF))
		else $error("distance beyond the unreachable mark");

endmodule

bind dijkstra_matrix_shortest_path dmsp_checker u_dmsp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.op             (op),
	.done           (done),
	.last           (last),
	.total_distance (total_distance)
);

`default_nettype wire

FILE: tb/sv/dijkstra_matrix_shortest_path_tb.sv
// self-checking testbench for the shortest path engine: edge loads, route queries, vertex count
`default_nettype none

module dijkstra_matrix_shortest_path_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dmsp_pkg::*;

	localparam int NV = MAX_VERTICES;
	localparam int WD_LIMIT = 40000;

	typedef struct {
		logic                   op;
		logic [VERTEX_BITS-1:0] from_v;
		logic [VERTEX_BITS-1:0] to_v;
		logic [7:0]             weight;
		logic [VERTEX_BITS-1:0] src;
		logic [VERTEX_BITS-1:0] dst;
	} cmd_t;

	typedef struct {
		logic [VERTEX_BITS-1:0] vtx;
		logic [DIST_BITS-1:0]   total;
		logic                   fin;
	} hop_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic op = OP_LOAD;
	logic [VERTEX_BITS-1:0] from_vertex = '0;
	logic [VERTEX_BITS-1:0] to_vertex = '0;
	logic [7:0] edge_weight = '0;
	logic [VERTEX_BITS-1:0] source = '0;
	logic [VERTEX_BITS-1:0] destination = '0;
	logic done;
	logic [VERTEX_BITS-1:0] path_vertex;
	logic [DIST_BITS-1:0] total_distance;
	logic last;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// predictor state
	logic [WEIGHT_BITS-1:0] edge_mem [NV][NV];
	logic [VCOUNT_BITS-1:0] vcount_reg = VCOUNT_RESET;

	cmd_t pending_q[$];
	hop_t route_q[$];
	cmd_t on_bus;
	int   send_idle_pct = 0;
	int   mismatches = 0;
	int   quiet_cycles = 0;

	dijkstra_matrix_shortest_path i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.from_vertex(from_vertex), .to_vertex(to_vertex), .edge_weight(edge_weight),
		.source(source), .destination(destination), .done(done),
		.path_vertex(path_vertex), .total_distance(total_distance), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// apply one accepted word to the model, queueing any route hops it yields
	function automatic void solve_route(cmd_t c);
		int n, cur, least, cand, len, v;
		int best [NV];
		bit seen [NV];
		bit has_pred [NV];
		int pred [NV];
		int trail [NV];
		hop_t h;
		if (c.op == OP_LOAD) begin
			edge_mem[c.from_v][c.to_v] = c.weight[WEIGHT_BITS-1:0];
			return;
		end
		n = (vcount_reg == 0) ? 1 : ((vcount_reg > NV) ? NV : int'(vcount_reg));
		h.vtx = c.dst;
		h.total = DIST_INF;
		h.fin = 1'b1;
		if (c.src >= n || c.dst >= n) begin
			route_q.push_back(h);
			return;
		end
		for (int i = 0; i < n; i++) begin
			best[i] = int'(DIST_INF);
			seen[i] = 0;
			has_pred[i] = 0;
			pred[i] = 0;
		end
		best[c.src] = 0;
		for (int r = 0; r + 1 < n; r++) begin
			least = int'(DIST_INF);
			cur = 0;
			// ties go to the higher index
			for (int i = 0; i < n; i++)
				if (!seen[i] && best[i] <= least) begin
					least = best[i];
					cur = i;
				end
			seen[cur] = 1;
			for (int i = 0; i < n; i++)
				if (!seen[i] && edge_mem[cur][i] != 0) begin
					cand = best[cur] + int'(edge_mem[cur][i]);
					if (cand < best[i]) begin
						best[i] = cand;
						pred[i] = cur;
						has_pred[i] = 1;
					end
				end
		end
		if (best[c.dst] >= int'(DIST_INF)) begin
			route_q.push_back(h);
			return;
		end
		// walk back from the destination, then emit source first
		len = 0;
		v = c.dst;
		forever begin
			trail[len] = v;
			len++;
			if (!has_pred[v] || len >= n) break;
			v = pred[v];
		end
		for (int k = len - 1; k >= 0; k--) begin
			h.vtx = VERTEX_BITS'(trail[k]);
			h.total = DIST_BITS'(best[c.dst]);
			h.fin = (k == 0);
			route_q.push_back(h);
		end
	endfunction

	function automatic cmd_t mk_load(int lim, int a, int b, int w);
		cmd_t c;
		c.op = OP_LOAD;
		c.from_v = VERTEX_BITS'((a < 0) ? $urandom_range(lim - 1) : a);
		c.to_v = VERTEX_BITS'((b < 0) ? $urandom_range(lim - 1) : b);
		c.weight = 8'((w < 0) ? $urandom_range(255) : w);
		c.src = VERTEX_BITS'($urandom);
		c.dst = VERTEX_BITS'($urandom);
		return c;
	endfunction

	function automatic cmd_t mk_query(int lim, int s, int d);
		cmd_t c;
		c.op = OP_QUERY;
		c.from_v = VERTEX_BITS'($urandom);
		c.to_v = VERTEX_BITS'($urandom);
		c.weight = 8'($urandom);
		c.src = VERTEX_BITS'((s < 0) ? $urandom_range(lim - 1) : s);
		c.dst = VERTEX_BITS'((d < 0) ? $urandom_range(lim - 1) : d);
		return c;
	endfunction

	// word driver: next item once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				solve_route(on_bus);
			if (!start || !busy) begin
				if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					on_bus = pending_q.pop_front();
					start <= 1'b1;
					op <= on_bus.op;
					from_vertex <= on_bus.from_v;
					to_vertex <= on_bus.to_v;
					edge_weight <= on_bus.weight;
					source <= on_bus.src;
					destination <= on_bus.dst;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		hop_t e;
		if (arst_n && done) begin
			if (route_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: vertex %0d dist %0d last %0b",
						path_vertex, total_distance, last);
			end else begin
				e = route_q.pop_front();
				if (path_vertex !== e.vtx || total_distance !== e.total || last !== e.fin) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word mismatch: exp %0d/%0d/%0b got %0d/%0d/%0b",
							e.vtx, e.total, e.fin, path_vertex, total_distance, last);
				end
			end
		end
	end

	// watchdog on cycles with no traffic
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable && pwrite) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("dijkstra_matrix_shortest_path verification failed");
			$finish;
		end
	end

	task automatic drain();
		while (pending_q.size() > 0 || start || route_q.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_vcount(int val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= REG_VERTEX_COUNT_ADDR;
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		vcount_reg = VCOUNT_BITS'(val);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		int counts [10] = '{4, 1, 0, 63, 8, 32, 6, 12, 2, 5};
		int n, lim, made;
		for (int i = 0; i < NV; i++)
			for (int j = 0; j < NV; j++)
				edge_mem[i][j] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: short chain, long edge, ties, deleted edge, self and unreachable
		pending_q.push_back(mk_load(NV, 0, 1, 10));
		pending_q.push_back(mk_load(NV, 1, 2, 20));
		pending_q.push_back(mk_load(NV, 0, 2, 40));
		pending_q.push_back(mk_load(NV, 2, 31, 255));
		pending_q.push_back(mk_load(NV, 31, 0, 1));
		pending_q.push_back(mk_query(NV, 0, 2));
		pending_q.push_back(mk_query(NV, 0, 31));
		pending_q.push_back(mk_query(NV, 31, 2));
		pending_q.push_back(mk_query(NV, 3, 3));
		pending_q.push_back(mk_query(NV, 0, 20));
		pending_q.push_back(mk_load(NV, 4, 5, 5));
		pending_q.push_back(mk_load(NV, 4, 6, 5));
		pending_q.push_back(mk_load(NV, 5, 7, 5));
		pending_q.push_back(mk_load(NV, 6, 7, 5));
		pending_q.push_back(mk_query(NV, 4, 7));
		pending_q.push_back(mk_load(NV, 0, 1, 0));
		pending_q.push_back(mk_query(NV, 0, 2));
		pending_q.push_back(mk_load(NV, 31, 31, 128));
		pending_q.push_back(mk_query(NV, 31, 31));
		drain();

		foreach (counts[p]) begin
			send_idle_pct = (p < 3) ? 37 : ((p < 6) ? 45 : 0);
			write_vcount(counts[p]);
			n = counts[p];
			lim = (n == 0) ? 1 : ((n > NV) ? NV : n);
			made = 0;
			while (made < 44) begin
				if ($urandom_range(9) < 8) begin
					// build some edges then ask for routes through them
					repeat ($urandom_range(1, 8)) begin
						pending_q.push_back(mk_load(lim, -1, -1,
							($urandom_range(7) == 0) ? 0 : -1));
						made++;
					end
					repeat ($urandom_range(1, 3)) begin
						pending_q.push_back(mk_query(lim, -1, -1));
						made++;
					end
				end else begin
					// noise: anywhere in the store, queries possibly out of range
					if ($urandom_range(1))
						pending_q.push_back(mk_load(NV, -1, -1, -1));
					else
						pending_q.push_back(mk_query(NV, -1, -1));
					made++;
				end
			end
			drain();
		end

		repeat (50) @(posedge clk);
		if (mismatches == 0 && route_q.size() == 0)
			$display("dijkstra_matrix_shortest_path verification clean");
		else
			$display("dijkstra_matrix_shortest_path verification failed");
		$finish;
	end

endmodule

`default_nettype wire
